// File: src/rspdf_pkg.sv
// package for the rsp packet deframer: constants, codes and the hex digit decoder
`default_nettype none
package rspdf_pkg;

    localparam int BUFFER_DEPTH = 512;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int LEN_W        = 9;

    localparam logic [ADDR_W-1:0] FILL_MAX = ADDR_W'(BUFFER_DEPTH - 1);

    localparam logic [7:0] CH_START = 8'h24;
    localparam logic [7:0] CH_END   = 8'h23;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [1:0] PH_WAIT    = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_CHK_HI  = 2'd2;
    localparam logic [1:0] PH_CHK_LO  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OK_SEQ   = 2'd1;
    localparam logic [1:0] ST_BAD_SUM  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_READ = 1'b1;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    localparam logic [1:0] SEQ_START = 2'd3;

    typedef struct packed {
        logic       kind;
        logic [1:0] status;
        logic [8:0] payload_length;
        logic [1:0] payload_start;
        logic [7:0] seq_first;
        logic [7:0] seq_second;
    } result_t;

    function automatic logic [7:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
        end else begin
            v = 8'hFF;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

// File: src/rsp_packet_deframer_core.sv
// rsp packet deframer top level: packet parser, payload memory and result register
//
// Input channel s_*: one transfer per received character (s_action = 0) or per
// read of a stored payload byte (s_action = 1, address s_read_index).
// Result channel m_*: a packet report when the second checksum digit arrives
// or when '#' closes a payload that filled the store, and one read-data
// transfer for every read. m_kind tells the two apart.
// From an input transfer to result valid, a result passes the first result stage
// (with the payload memory read register) and then the output register.
// Throughput is one transfer per cycle while s_ready is high; parser state updates
// in the cycle of the transfer and the memory takes one write or one read per cycle.
// Stored bytes 0 to 2 are also held in flip-flops for the sequence check.
// Reset (aresetn low, synchronous) returns the parser to waiting for '$'
// and empties both result stages; memory contents are not cleared.
// When the receiver stalls, one result waits in the output register and one
// in the stage behind it; s_ready drops only when both are full.
`default_nettype none
module rsp_packet_deframer_core
    import rspdf_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_action,
    input  wire logic [7:0] s_rx_byte,
    input  wire logic [8:0] s_read_index,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_kind,
    output logic [1:0]      m_status,
    output logic [8:0]      m_payload_length,
    output logic [1:0]      m_payload_start,
    output logic [7:0]      m_seq_first,
    output logic [7:0]      m_seq_second,
    output logic [7:0]      m_read_data
);

    logic [7:0] payload_mem [BUFFER_DEPTH];

    logic [1:0]      phase_reg, phase_next;
    logic [7:0]      sum_reg, sum_next;
    logic [7:0]      sum_hi_reg, sum_hi_next;
    logic [ADDR_W:0] fill_reg, fill_next;
    logic [7:0]      byte0_reg, byte1_reg, byte2_reg;
    logic [7:0]      rd_data_reg;

    logic    p1_valid_reg;
    result_t p1_res_reg;
    logic    m_valid_reg;
    result_t m_res_reg;
    logic [7:0] m_data_reg;

    logic    accept, p1_adv, store_en, res_en;
    result_t res;
    logic [7:0] rx_sum;
    logic [3:0] hi_nibble;

    assign p1_adv  = p1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !p1_valid_reg || p1_adv;
    assign accept  = s_valid && s_ready;

    always_comb begin
        phase_next  = phase_reg;
        sum_next    = sum_reg;
        sum_hi_next = sum_hi_reg;
        fill_next   = fill_reg;
        store_en    = 1'b0;
        res_en      = 1'b0;
        res         = '0;
        rx_sum      = sum_hi_reg + hex_value(s_rx_byte);
        hi_nibble   = 4'(hex_value(s_rx_byte));
        if (s_action == ACT_READ) begin
            res_en   = 1'b1;
            res.kind = KIND_READ;
        end else begin
            unique case (phase_reg)
                PH_WAIT, PH_PAYLOAD: begin
                    if (s_rx_byte == CH_START) begin
                        phase_next  = PH_PAYLOAD;
                        sum_next    = '0;
                        fill_next   = '0;
                        sum_hi_next = '0;
                    end else if (phase_reg == PH_PAYLOAD) begin
                        if (s_rx_byte == CH_END) begin
                            if (fill_reg[ADDR_W-1:0] == FILL_MAX) begin
                                phase_next         = PH_WAIT;
                                res_en             = 1'b1;
                                res.kind           = KIND_REPORT;
                                res.status         = ST_OVERFLOW;
                                res.payload_length = LEN_W'(fill_reg);
                            end else begin
                                phase_next = PH_CHK_HI;
                            end
                        end else begin
                            if (fill_reg[ADDR_W-1:0] != FILL_MAX) begin
                                store_en  = 1'b1;
                                fill_next = fill_reg + 1'b1;
                            end
                            sum_next = sum_reg + s_rx_byte;
                        end
                    end
                end
                PH_CHK_HI: begin
                    sum_hi_next = {hi_nibble, 4'h0};
                    phase_next  = PH_CHK_LO;
                end
                PH_CHK_LO: begin
                    phase_next         = PH_WAIT;
                    res_en             = 1'b1;
                    res.kind           = KIND_REPORT;
                    res.payload_length = LEN_W'(fill_reg);
                    if (rx_sum != sum_reg) begin
                        res.status = ST_BAD_SUM;
                    end else if (fill_reg >= (ADDR_W+1)'(3) && byte2_reg == CH_COLON) begin
                        res.status        = ST_OK_SEQ;
                        res.payload_start = SEQ_START;
                        res.seq_first     = byte0_reg;
                        res.seq_second    = byte1_reg;
                    end else begin
                        res.status = ST_OK;
                    end
                end
                default: phase_next = PH_WAIT;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && store_en) begin
            payload_mem[fill_reg[ADDR_W-1:0]] <= s_rx_byte;
        end
        if (accept && s_action == ACT_READ) begin
            rd_data_reg <= payload_mem[s_read_index[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && store_en) begin
            if (fill_reg == (ADDR_W+1)'(0)) begin
                byte0_reg <= s_rx_byte;
            end
            if (fill_reg == (ADDR_W+1)'(1)) begin
                byte1_reg <= s_rx_byte;
            end
            if (fill_reg == (ADDR_W+1)'(2)) begin
                byte2_reg <= s_rx_byte;
            end
        end
        if (accept && res_en) begin
            p1_res_reg <= res;
        end
        if (p1_adv) begin
            m_res_reg  <= p1_res_reg;
            m_data_reg <= (p1_res_reg.kind == KIND_READ) ? rd_data_reg : 8'h00;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_WAIT;
            sum_reg      <= '0;
            sum_hi_reg   <= '0;
            fill_reg     <= '0;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg  <= phase_next;
                sum_reg    <= sum_next;
                sum_hi_reg <= sum_hi_next;
                fill_reg   <= fill_next;
            end
            if (accept && res_en) begin
                p1_valid_reg <= 1'b1;
            end else if (p1_adv) begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_kind           = m_res_reg.kind;
    assign m_status         = m_res_reg.status;
    assign m_payload_length = m_res_reg.payload_length;
    assign m_payload_start  = m_res_reg.payload_start;
    assign m_seq_first      = m_res_reg.seq_first;
    assign m_seq_second     = m_res_reg.seq_second;
    assign m_read_data      = m_data_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= (ADDR_W+1)'(BUFFER_DEPTH - 1))
        else $error("fill count beyond store");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (p1_valid_reg && m_valid_reg && !m_ready))
        else $error("input stalled with free result stage");

    a_report_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_action == ACT_BYTE && phase_reg == PH_CHK_LO)
        |=> (phase_reg == PH_WAIT && p1_valid_reg && p1_res_reg.kind == KIND_REPORT))
        else $error("checksum end without report");

    a_read_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_READ) |-> (m_status == ST_OK && m_payload_length == 9'd0))
        else $error("read result carries report fields");

endmodule
`default_nettype wire
